### rtl/fcc_pkg.sv
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared types and constants of the framed command catcher.
// ----------------------------------------------------------------------------
package fcc_pkg;

    localparam int FCC_BUF_SIZE = 64;
    localparam int FCC_AW       = $clog2(FCC_BUF_SIZE);
    // write position folds back to zero when it would reach this value
    localparam logic [FCC_AW-1:0] FCC_WRAP = FCC_AW'(FCC_BUF_SIZE - 1);

    localparam int FCC_QDEPTH = 2;
    localparam int FCC_QAW    = $clog2(FCC_QDEPTH);
    localparam int FCC_QCW    = $clog2(FCC_QDEPTH + 1);

    // configuration register indexes
    localparam logic [1:0] CFG_START_MARKER = 2'd0;
    localparam logic [1:0] CFG_FIRST_END    = 2'd1;
    localparam logic [1:0] CFG_SECOND_END   = 2'd2;

    localparam logic [7:0] RST_START_MARKER = 8'd35;
    localparam logic [7:0] RST_FIRST_END    = 8'd13;
    localparam logic [7:0] RST_SECOND_END   = 8'd10;

    // front -> back command
    typedef struct packed {
        logic              store;   // write data at addr
        logic              replay;  // replay positions 0 .. len-1 afterwards
        logic [FCC_AW-1:0] addr;
        logic [7:0]        data;
        logic [FCC_AW-1:0] len;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_stat;

endpackage

### rtl/framed_command_catcher.sv
// Throughput: one received byte per cycle while the 2-entry command queue has room;
//   replay moves one byte per cycle from the 64-entry frame store, throttled by i_m_tready.
// The receive side stalls during a replay once the queue fills behind it.
// Reset (i_rst_n low, synchronous): parser idle, write position 0, queue empty,
//   markers back to '#', CR, LF; frame store contents are left as they are.
// ----------------------------------------------------------------------------
// framed_command_catcher
// Catches start-marker / CR LF framed commands from a byte stream and replays
// each completed frame on the output stream up to its first zero byte, last byte flagged by tlast.
// ----------------------------------------------------------------------------
module framed_command_catcher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write port
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,     // 0 start, 1 first end, 2 second end marker
    input  logic [7:0] i_cfg_data,
    // received bytes
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,     // [7:0] rx_byte
    // replayed frame
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,     // [7:0] tx_byte
    output logic       o_m_tlast      // frame_end
);
    import fcc_pkg::*;

    t_cmd       front_cmd;
    t_cmd       head_cmd;
    t_fifo_stat q_stat;
    logic       front_push;
    logic       back_pop;
    logic       in_accept;

    // front only blocks when the command queue is full
    assign o_s_tready = !q_stat.full;
    assign in_accept  = i_s_tvalid && o_s_tready;

    // parser: phase, write position and markers
    fcc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (in_accept),
        .i_byte     (i_s_tdata),
        .o_push     (front_push),
        .o_cmd      (front_cmd)
    );

    // decouples parsing from replay so each side stalls on its own
    fcc_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .i_pop   (back_pop),
        .o_head  (head_cmd),
        .o_stat  (q_stat)
    );

    // frame store and replay sequencer; stores execute in arrival order,
    // so a replay always sees exactly the bytes written before it
    fcc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (head_cmd),
        .i_stat  (q_stat),
        .o_pop   (back_pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_byte  (o_m_tdata),
        .o_last  (o_m_tlast)
    );

endmodule

### rtl/fcc_front.sv
// ----------------------------------------------------------------------------
// fcc_front
// Frame parser: tracks the marker phase and write position, turns each
// accepted frame byte into a store/replay command; other bytes are dropped.
// ----------------------------------------------------------------------------
module fcc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [7:0]     i_cfg_data,
    input  logic           i_accept,
    input  logic [7:0]     i_byte,
    output logic           o_push,
    output fcc_pkg::t_cmd  o_cmd
);
    import fcc_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_END1,
        PH_END2
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [FCC_AW-1:0] r_wp, n_wp;
    logic [7:0]        r_start, r_end1, r_end2;

    function automatic logic [FCC_AW-1:0] next_pos(input logic [FCC_AW-1:0] p);
        logic [FCC_AW-1:0] q;
        q = p + FCC_AW'(1);
        return (q == FCC_WRAP) ? '0 : q;
    endfunction

    always_comb begin
        n_phase = r_phase;
        n_wp    = r_wp;
        o_push  = 1'b0;
        o_cmd   = '0;
        o_cmd.data = i_byte;
        if (i_accept) begin
            unique case (r_phase)
                PH_END1: begin
                    o_push       = 1'b1;
                    o_cmd.store  = 1'b1;
                    o_cmd.addr   = r_wp;
                    n_wp         = next_pos(r_wp);
                    if (i_byte == r_end1) begin
                        n_phase = PH_END2;
                    end
                end
                PH_END2: begin
                    o_push      = 1'b1;
                    o_cmd.store = 1'b1;
                    n_phase     = PH_IDLE;
                    if (i_byte == r_end2) begin
                        o_cmd.addr   = r_wp;
                        n_wp         = next_pos(r_wp);
                        o_cmd.replay = 1'b1;
                        o_cmd.len    = n_wp;
                    end else begin
                        // broken terminator: store this byte at 0 and go back to idle
                        o_cmd.addr = '0;
                        n_wp       = next_pos('0);
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    if (i_byte == r_start) begin
                        o_push      = 1'b1;
                        o_cmd.store = 1'b1;
                        o_cmd.addr  = '0;
                        n_wp        = next_pos('0);
                        n_phase     = PH_END1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_wp    <= '0;
            r_start <= RST_START_MARKER;
            r_end1  <= RST_FIRST_END;
            r_end2  <= RST_SECOND_END;
        end else begin
            r_phase <= n_phase;
            r_wp    <= n_wp;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_START_MARKER: r_start <= i_cfg_data;
                    CFG_FIRST_END:    r_end1  <= i_cfg_data;
                    CFG_SECOND_END:   r_end2  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    a_wp_never_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp != FCC_WRAP) else $error("write position reached wrap value");
    // a wrapped frame may end with length 0; the terminator is still stored
    a_replay_has_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_cmd.replay) |-> o_cmd.store)
        else $error("replay command without stored terminator");
    a_idle_no_push_unless_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && r_phase == PH_IDLE) |=> r_phase == PH_END1)
        else $error("idle push did not open a frame");
`endif

endmodule

### rtl/fcc_cmd_fifo.sv
// ----------------------------------------------------------------------------
// fcc_cmd_fifo
// Short command queue between parser and replay engine.
// ----------------------------------------------------------------------------
module fcc_cmd_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  fcc_pkg::t_cmd       i_cmd,
    input  logic                i_pop,
    output fcc_pkg::t_cmd       o_head,
    output fcc_pkg::t_fifo_stat o_stat
);
    import fcc_pkg::*;

    t_cmd               r_q [FCC_QDEPTH];
    logic [FCC_QAW-1:0] r_wptr, r_rptr;
    logic [FCC_QCW-1:0] r_count;
    logic               do_push, do_pop;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == FCC_QCW'(FCC_QDEPTH));
    assign o_head       = r_q[r_rptr];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == FCC_QAW'(FCC_QDEPTH - 1)) ? '0 : r_wptr + FCC_QAW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == FCC_QAW'(FCC_QDEPTH - 1)) ? '0 : r_rptr + FCC_QAW'(1);
            end
            r_count <= r_count + FCC_QCW'(do_push) - FCC_QCW'(do_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.full |-> !i_push) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.empty |-> !i_pop) else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FCC_QCW'(FCC_QDEPTH)) else $error("queue count overflow");
`endif

endmodule

### rtl/fcc_back.sv
// ----------------------------------------------------------------------------
// fcc_back
// Replay engine: owns the frame store, runs store commands, plays a completed
// frame out with one byte of lookahead, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module fcc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fcc_pkg::t_cmd       i_cmd,
    input  fcc_pkg::t_fifo_stat i_stat,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_byte,
    output logic                o_last
);
    import fcc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_EVAL,
        S_TAIL
    } t_state;

    logic [7:0]        r_mem [FCC_BUF_SIZE];
    logic [7:0]        r_rdata;
    logic [FCC_AW-1:0] rd_addr;
    logic              mem_we;

    t_state            r_state, n_state;
    logic [FCC_AW-1:0] r_idx, n_idx;
    logic [FCC_AW-1:0] r_len, n_len;
    logic [7:0]        r_cur, n_cur;
    logic              r_have, n_have;
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_out_byte, n_out_byte;
    logic              r_out_last, n_out_last;
    logic              out_free;

    assign out_free = !r_out_valid || i_ready;
    assign rd_addr  = n_idx;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_len       = r_len;
        n_cur       = r_cur;
        n_have      = r_have;
        n_out_valid = r_out_valid && !i_ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_stat.empty) begin
                    o_pop  = 1'b1;
                    mem_we = i_cmd.store;
                    if (i_cmd.replay && i_cmd.len != '0) begin
                        n_len   = i_cmd.len;
                        n_have  = 1'b0;
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                // store write has landed; fetch position 0
                n_idx   = '0;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (r_rdata == 8'd0) begin
                    // zero byte ends the frame early
                    if (!r_have) begin
                        n_state = S_IDLE;
                    end else if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_byte  = r_cur;
                        n_out_last  = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else if (!r_have || out_free) begin
                    if (r_have) begin
                        n_out_valid = 1'b1;
                        n_out_byte  = r_cur;
                        n_out_last  = 1'b0;
                    end
                    n_cur  = r_rdata;
                    n_have = 1'b1;
                    if (r_idx == r_len - FCC_AW'(1)) begin
                        n_state = S_TAIL;
                    end else begin
                        n_idx = r_idx + FCC_AW'(1);
                    end
                end
            end
            S_TAIL: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_cur;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_cmd.addr] <= i_cmd.data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
        end
        r_idx      <= n_idx;
        r_len      <= n_len;
        r_cur      <= n_cur;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

`ifndef SYNTHESIS
    a_no_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_byte != 8'd0) else $error("zero byte replayed");
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> r_idx < r_len) else $error("replay index past length");
    a_tail_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAIL) |-> r_have) else $error("tail without pending byte");
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == S_IDLE) else $error("command taken during replay");
`endif

endmodule
